/* rtl/bsph_pkg.sv */
`default_nettype none

package bsph_pkg;

    localparam int MAX_VERTS_DEF = 1024;
    localparam int COORD_W       = 32;
    localparam int DIST_W        = 32;
    localparam int SQ_W          = 64;
    localparam int ROOT_W        = 32;
    localparam int RADIUS_W      = 33;
    localparam int SQRT_STEPS    = SQ_W / 2;
    localparam int STEP_W        = $clog2(SQRT_STEPS);

    typedef struct packed {
        logic load;
        logic begin_compute;
        logic rd;
        logic root_init;
        logic root_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic count_zero;
        logic last;
        logic pipe_empty;
    } t_dp_status;

endpackage

`default_nettype wire

/* rtl/bsph_ctrl.sv */
`default_nettype none

module bsph_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    input  wire                  i_func,
    input  bsph_pkg::t_dp_status i_status,
    output bsph_pkg::t_dp_cmd    o_cmd,
    output logic                 busy,
    output logic                 o_strobe
);
    import bsph_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_ROOT  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_strobe;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_func) begin
                        o_cmd.begin_compute = 1'b1;
                        n_state = i_status.count_zero ? ST_FIN : ST_WALK;
                    end else begin
                        o_cmd.load = !i_status.full;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.rd = 1'b1;
                if (i_status.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    o_cmd.root_init = 1'b1;
                    n_step  = '0;
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_strobe <= (r_state == ST_FIN);
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

/* rtl/bsph_dp.sv */
`default_nettype none

module bsph_dp #(
    parameter int MAX_VERTS = bsph_pkg::MAX_VERTS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  bsph_pkg::t_dp_cmd                   i_cmd,
    input  wire signed [bsph_pkg::COORD_W-1:0]  i_vx,
    input  wire signed [bsph_pkg::COORD_W-1:0]  i_vy,
    input  wire signed [bsph_pkg::COORD_W-1:0]  i_vz,
    input  wire                                 i_clear_radius,
    output bsph_pkg::t_dp_status                o_status,
    output logic signed [bsph_pkg::COORD_W-1:0] o_center_x,
    output logic signed [bsph_pkg::COORD_W-1:0] o_center_y,
    output logic signed [bsph_pkg::COORD_W-1:0] o_center_z,
    output logic [bsph_pkg::RADIUS_W-1:0]       o_radius,
    output logic                                o_empty_res
);
    import bsph_pkg::*;

    localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
    localparam int CW = $clog2(MAX_VERTS + 1);

    logic [3*COORD_W-1:0] mem [MAX_VERTS];
    logic [3*COORD_W-1:0] r_rd;

    logic [CW-1:0] r_count;
    logic [AW-1:0] r_addr;

    logic signed [COORD_W-1:0] r_min [3];
    logic signed [COORD_W-1:0] r_max [3];
    logic signed [COORD_W-1:0] r_center [3];
    logic signed [COORD_W-1:0] v_in [3];
    logic signed [COORD_W-1:0] v_rd [3];
    logic signed [COORD_W-1:0] mid [3];
    logic signed [COORD_W:0]   box_sum [3];
    logic signed [COORD_W:0]   box_adj [3];
    logic signed [COORD_W:0]   diff [3];
    logic [DIST_W-1:0]         r_dist [3];
    logic [SQ_W-1:0]           r_sq [3];
    logic [SQ_W-1:0]           r_sum;
    logic [SQ_W-1:0]           r_best;
    logic                      r_v0, r_v1, r_v2, r_v3;

    logic [SQ_W-1:0]     r_n;
    logic [ROOT_W:0]     r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+3:0]   trial;

    logic [RADIUS_W-1:0] r_radius;
    logic [RADIUS_W-1:0] cand;
    logic                r_empty;

    assign v_in[0] = i_vx;
    assign v_in[1] = i_vy;
    assign v_in[2] = i_vz;
    assign v_rd[0] = r_rd[COORD_W-1:0];
    assign v_rd[1] = r_rd[2*COORD_W-1:COORD_W];
    assign v_rd[2] = r_rd[3*COORD_W-1:2*COORD_W];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            box_sum[a] = {r_min[a][COORD_W-1], r_min[a]} + {r_max[a][COORD_W-1], r_max[a]};
            box_adj[a] = box_sum[a] + {{COORD_W{1'b0}}, box_sum[a][COORD_W]};
            mid[a]     = box_adj[a][COORD_W:1];
            diff[a]    = {v_rd[a][COORD_W-1], v_rd[a]} -
                         {r_center[a][COORD_W-1], r_center[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[r_count[AW-1:0]] <= {i_vz, i_vy, i_vx};
        end
        if (i_cmd.rd) begin
            r_rd <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_radius <= '0;
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
        end else begin
            r_v0 <= i_cmd.rd;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.load) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.finish) begin
                r_count <= '0;
            end
            if (i_cmd.begin_compute && i_clear_radius) begin
                r_radius <= '0;
            end else if (i_cmd.finish && !r_empty && cand > r_radius) begin
                r_radius <= cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int a = 0; a < 3; a++) begin
                if (r_count == '0 || v_in[a] < r_min[a]) begin
                    r_min[a] <= v_in[a];
                end
                if (r_count == '0 || v_in[a] > r_max[a]) begin
                    r_max[a] <= v_in[a];
                end
            end
        end
        if (i_cmd.begin_compute) begin
            r_empty <= (r_count == '0);
            r_addr  <= '0;
            r_best  <= '0;
            for (int a = 0; a < 3; a++) begin
                r_center[a] <= (r_count == '0) ? '0 : mid[a];
            end
        end
        if (i_cmd.rd) begin
            r_addr <= r_addr + AW'(1);
        end
        for (int a = 0; a < 3; a++) begin
            r_dist[a] <= diff[a][COORD_W] ? DIST_W'(-diff[a]) : diff[a][DIST_W-1:0];
            r_sq[a]   <= SQ_W'(r_dist[a]) * SQ_W'(r_dist[a]);
        end
        r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        if (r_v3 && r_sum > r_best) begin
            r_best <= r_sum;
        end
        if (i_cmd.root_init) begin
            r_n    <= r_best;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_n <= {r_n[SQ_W-3:0], 2'b00};
            if (!trial[ROOT_W+3]) begin
                r_rem  <= trial[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[ROOT_W:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign rem_sh = {r_rem, r_n[SQ_W-1:SQ_W-2]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_root, 2'b01};
    assign cand   = RADIUS_W'(r_root);

    assign o_status.full       = (r_count == CW'(MAX_VERTS));
    assign o_status.count_zero = (r_count == '0);
    assign o_status.last       = (CW'(r_addr) == r_count - CW'(1));
    assign o_status.pipe_empty = !(r_v0 || r_v1 || r_v2 || r_v3);

    assign o_center_x  = r_center[0];
    assign o_center_y  = r_center[1];
    assign o_center_z  = r_center[2];
    assign o_radius    = r_radius;
    assign o_empty_res = r_empty;

endmodule

`default_nettype wire

/* rtl/bounding_sphere_of_vertices_unit.sv */
`default_nettype none

// A load (func 0) does not raise busy, so vertices can be sent back to back
// while busy is low; a load that finds the store full is dropped. A compute
// (func 1) raises busy, walks the N loaded vertices through the single read
// port of the vertex memory at one per cycle, waits for the distance
// pipeline to empty, loads the square root, and then runs a square root
// that delivers one result bit per cycle. Busy stays high until the result
// is written, and the result follows in the next cycle; with no vertices
// loaded busy is high for one cycle. The result is presented for exactly
// one cycle with o_strobe high, and the receiver cannot stall it.
module bounding_sphere_of_vertices_unit #(
    parameter int MAX_VERTS = bsph_pkg::MAX_VERTS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 i_func,
    input  wire signed [bsph_pkg::COORD_W-1:0]  i_vx,
    input  wire signed [bsph_pkg::COORD_W-1:0]  i_vy,
    input  wire signed [bsph_pkg::COORD_W-1:0]  i_vz,
    input  wire                                 i_clear_radius,
    output logic                                o_strobe,
    output logic signed [bsph_pkg::COORD_W-1:0] o_center_x,
    output logic signed [bsph_pkg::COORD_W-1:0] o_center_y,
    output logic signed [bsph_pkg::COORD_W-1:0] o_center_z,
    output logic [bsph_pkg::RADIUS_W-1:0]       o_radius,
    output logic                                o_empty_res
);
    import bsph_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    bsph_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    bsph_dp #(
        .MAX_VERTS (MAX_VERTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_vx           (i_vx),
        .i_vy           (i_vy),
        .i_vz           (i_vz),
        .i_clear_radius (i_clear_radius),
        .o_status       (status),
        .o_center_x     (o_center_x),
        .o_center_y     (o_center_y),
        .o_center_z     (o_center_z),
        .o_radius       (o_radius),
        .o_empty_res    (o_empty_res)
    );

endmodule

`default_nettype wire
